FILE: src/deac_pkg.sv
package deac_pkg;

  // Default supersample grid size along one axis
  localparam int unsigned SamplesDef = 30;
  // Q.8 endpoint coordinate width (covers distances up to 31 plus offset)
  localparam int unsigned CoordW = 16;
  // Configuration register width
  localparam int unsigned CfgW = 10;
  // Output field width
  localparam int unsigned AreaW = 11;

  typedef struct packed {
    logic [3:0] edge_pattern;
    logic [4:0] left_distance;
    logic [4:0] right_distance;
  } in_word_t;

  typedef struct packed {
    logic [AreaW-1:0] area_first;
    logic [AreaW-1:0] area_second;
  } out_word_t;

  typedef enum logic {
    REG_OFFSET_X = 1'b0,
    REG_OFFSET_Y = 1'b1
  } cfg_reg_e;

  // Microprogram addresses
  typedef enum logic [3:0] {
    S_IDLE  = 4'd0,
    S_SEG   = 4'd1,
    S_DIFF  = 4'd2,
    S_PIX   = 4'd3,
    S_MULX  = 4'd4,
    S_MULY  = 4'd5,
    S_SCAN  = 4'd6,
    S_ACC   = 4'd7,
    S_NSEG  = 4'd8,
    S_EMIT  = 4'd9
  } step_e;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_LATCH,
    OP_ENDPTS,
    OP_DIFF,
    OP_TERMS,
    OP_MULX,
    OP_MULY,
    OP_SCAN,
    OP_ACCUM,
    OP_NSEG,
    OP_EMIT
  } op_e;

  // Jump conditions: taken -> target, not taken -> next
  typedef enum logic [2:0] {
    C_NEVER,
    C_NO_IN,
    C_SCAN_BUSY,
    C_PIX_LEFT,
    C_SEG_LEFT,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_e target;
    step_e next;
  } ctrl_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic in_valid;
    logic scan_last;
    logic pix_left;
    logic seg_left;
    logic out_busy;
  } stat_t;

  // Control store
  function automatic ctrl_t ucode(step_e s);
    ctrl_t w;
    w = '{op: OP_LATCH, cond: C_NO_IN, target: S_IDLE, next: S_SEG};
    case (s)
      S_IDLE: w = '{op: OP_LATCH,  cond: C_NO_IN,     target: S_IDLE, next: S_SEG};
      S_SEG:  w = '{op: OP_ENDPTS, cond: C_NEVER,     target: S_IDLE, next: S_DIFF};
      S_DIFF: w = '{op: OP_DIFF,   cond: C_NEVER,     target: S_IDLE, next: S_PIX};
      S_PIX:  w = '{op: OP_TERMS,  cond: C_NEVER,     target: S_IDLE, next: S_MULX};
      S_MULX: w = '{op: OP_MULX,   cond: C_NEVER,     target: S_IDLE, next: S_MULY};
      S_MULY: w = '{op: OP_MULY,   cond: C_NEVER,     target: S_IDLE, next: S_SCAN};
      S_SCAN: w = '{op: OP_SCAN,   cond: C_SCAN_BUSY, target: S_SCAN, next: S_ACC};
      S_ACC:  w = '{op: OP_ACCUM,  cond: C_PIX_LEFT,  target: S_PIX,  next: S_NSEG};
      S_NSEG: w = '{op: OP_NSEG,   cond: C_SEG_LEFT,  target: S_SEG,  next: S_EMIT};
      S_EMIT: w = '{op: OP_EMIT,   cond: C_OUT_BUSY,  target: S_EMIT, next: S_IDLE};
      default: w = '{op: OP_LATCH, cond: C_NO_IN,     target: S_IDLE, next: S_SEG};
    endcase
    return w;
  endfunction

  // Segment codes per pattern, {second, first}; each code is
  // {end offset, end y, end x, start offset, start y, start x}
  function automatic logic [11:0] seg_pair(logic [3:0] pat);
    logic [11:0] r;
    r = '0;
    case (pat)
      4'd0:  r = {6'b001001, 6'b011011};
      4'd1:  r = {6'b111001, 6'b111000};
      4'd2:  r = {6'b101001, 6'b101000};
      4'd3:  r = {6'b001001, 6'b111000};
      4'd4:  r = {6'b001101, 6'b000101};
      4'd5:  r = {6'b000000, 6'b111101};
      4'd6:  r = {6'b000000, 6'b101101};
      4'd7:  r = {6'b001101, 6'b111101};
      4'd8:  r = {6'b001111, 6'b000111};
      4'd9:  r = {6'b000000, 6'b111111};
      4'd10: r = {6'b000000, 6'b101111};
      4'd11: r = {6'b101111, 6'b111111};
      4'd12: r = {6'b001101, 6'b000111};
      4'd13: r = {6'b111101, 6'b111111};
      4'd14: r = {6'b101101, 6'b101111};
      4'd15: r = {6'b101101, 6'b111111};
      default: r = '0;
    endcase
    return r;
  endfunction

  // Patterns with a single segment get their areas doubled
  function automatic logic seg_two(logic [3:0] pat);
    return !(pat == 4'd5 || pat == 4'd6 || pat == 4'd9 || pat == 4'd10);
  endfunction

endpackage

FILE: src/deac_sequencer.sv
module deac_sequencer
  import deac_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  step_e step_q, step_d;
  ctrl_t ctl;
  logic  taken;

  // Control word fetch
  assign ctl    = ucode(step_q);
  assign ctrl_o = ctl;

  // Branch condition
  always_comb begin
    case (ctl.cond)
      C_NEVER:     taken = 1'b0;
      C_NO_IN:     taken = !stat_i.in_valid;
      C_SCAN_BUSY: taken = !stat_i.scan_last;
      C_PIX_LEFT:  taken = stat_i.pix_left;
      C_SEG_LEFT:  taken = stat_i.seg_left;
      C_OUT_BUSY:  taken = stat_i.out_busy;
      default:     taken = 1'b0;
    endcase
    step_d = taken ? ctl.target : ctl.next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

`ifndef SYNTH
  a_scan_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == S_SCAN && !stat_i.scan_last) |=> step_q == S_SCAN)
    else $error("sample scan left early");

  a_emit_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == S_EMIT && !stat_i.out_busy) |=> step_q == S_IDLE)
    else $error("sequencer did not return to idle after emit");
`endif

endmodule

FILE: src/deac_datapath.sv
module deac_datapath
  import deac_pkg::*;
#(
  parameter int unsigned SAMPLES = SamplesDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ctrl_t           ctrl_i,
  output stat_t           stat_o,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_word_t        in_word_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_word_t       out_word_o,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [CfgW-1:0] cfg_wdata_i
);

  localparam int unsigned IdxW = $clog2(SAMPLES);
  localparam int unsigned CntW = $clog2(SAMPLES * SAMPLES + 1);
  localparam int unsigned DW   = CoordW + 1;          // pixel minus endpoint sum
  localparam int unsigned TW   = DW + IdxW + 1;       // scaled by SAMPLES-1
  localparam int unsigned PW   = CoordW + TW;         // one line product
  localparam int unsigned FW   = PW + 2;              // line function value
  localparam logic [IdxW-1:0]   SLast = IdxW'(SAMPLES - 1);
  localparam logic signed [IdxW:0] S1 = (IdxW + 1)'(SAMPLES - 1);
  localparam logic [CntW-1:0]   Full  = CntW'(SAMPLES * SAMPLES);

  // configuration
  logic signed [CfgW-1:0] offx_q, offy_q;

  // item
  logic [3:0] pat_q;
  logic [4:0] left_q, right_q;
  logic       k_q, pix_q, two_q;

  // segment geometry
  logic signed [CoordW-1:0] ax_q, ay_q, bx_q, by_q;
  logic signed [CoordW-1:0] la_q, lb_q, sumx_q, sumy_q;
  logic                     degen_q;
  logic signed [TW-1:0]     tx_q, ty_q;
  logic signed [PW-1:0]     p_q;
  logic signed [FW-1:0]     frow_q, cur_q;
  logic [IdxW-1:0]          x_q, y_q;
  logic [CntW-1:0]          cnt_q;
  logic [AreaW-1:0]         a1_q, a2_q;

  // output register
  logic      out_valid_q;
  out_word_t out_q;

  // endpoint construction
  logic [11:0]              pair;
  logic [5:0]               seg;
  logic [5:0]               reach;
  logic signed [CoordW-1:0] oxe, oye, axb, ayb, bxb, byb;
  logic signed [CoordW-1:0] ax_d, ay_d, bx_d, by_d;

  // pixel terms
  logic [5:0]               px, py;
  logic signed [DW-1:0]     pxs, pys, dx, dy;

  // scan
  logic signed [FW-1:0]     xstep, ystep, ynext, f0;
  logic signed [PW-1:0]     mul_y;
  logic                     pos_hit, last_y, last_x;
  logic [CntW-1:0]          ceff;
  logic                     in_fire, out_busy;

  assign in_ready_o  = (ctrl_i.op == OP_LATCH);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_busy    = out_valid_q && !out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // Segment endpoints in Q.8
  always_comb begin
    pair  = seg_pair(pat_q);
    seg   = k_q ? pair[11:6] : pair[5:0];
    reach = {1'b0, left_q} + {1'b0, right_q} + 6'd1;
    oxe   = {{(CoordW-CfgW){offx_q[CfgW-1]}}, offx_q};
    oye   = {{(CoordW-CfgW){offy_q[CfgW-1]}}, offy_q};
    axb   = {{(CoordW-9){1'b0}}, seg[0], 8'h00};
    ayb   = {{(CoordW-9){1'b0}}, seg[1], 8'h00};
    bxb   = {{(CoordW-15){1'b0}}, ({1'b0, reach} + {6'd0, seg[3]}), 8'h00};
    byb   = {{(CoordW-15){1'b0}}, ({1'b0, reach} + {6'd0, seg[4]}), 8'h00};
    ax_d  = axb + (seg[2] ? oxe : '0);
    ay_d  = ayb + (seg[2] ? oye : '0);
    bx_d  = bxb + (seg[5] ? oxe : '0);
    by_d  = byb + (seg[5] ? oye : '0);
  end

  // Sample grid origin relative to the segment midpoint, doubled Q.8
  always_comb begin
    px  = {1'b0, left_q} + 6'd1;
    py  = {1'b0, left_q} + {5'd0, pix_q};
    pxs = {{(DW-15){1'b0}}, px, 9'd0};
    pys = {{(DW-15){1'b0}}, py, 9'd0};
    dx  = pxs - DW'(sumx_q);
    dy  = pys - DW'(sumy_q);
  end

  // Line function stepping and counting
  always_comb begin
    xstep   = FW'(la_q) <<< 9;
    ystep   = FW'(lb_q) <<< 9;
    ynext   = frow_q + xstep;
    mul_y   = PW'(lb_q) * PW'(ty_q);
    f0      = FW'(p_q) + FW'(mul_y);
    pos_hit = !cur_q[FW-1] && (cur_q != '0);
    last_y  = (y_q == SLast);
    last_x  = (x_q == SLast);
    ceff    = degen_q ? Full : cnt_q;
  end

  assign stat_o = '{in_valid:  in_valid_i,
                    scan_last: last_x && last_y,
                    pix_left:  !pix_q,
                    seg_left:  !k_q && two_q,
                    out_busy:  out_busy};

  // Datapath registers, one operation per control word
  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      OP_LATCH: begin
        if (in_valid_i) begin
          pat_q   <= in_word_i.edge_pattern;
          left_q  <= in_word_i.left_distance;
          right_q <= in_word_i.right_distance;
          two_q   <= seg_two(in_word_i.edge_pattern);
          k_q     <= 1'b0;
          pix_q   <= 1'b0;
          a1_q    <= '0;
          a2_q    <= '0;
        end
      end
      OP_ENDPTS: begin
        ax_q <= ax_d;
        ay_q <= ay_d;
        bx_q <= bx_d;
        by_q <= by_d;
      end
      OP_DIFF: begin
        la_q    <= by_q - ay_q;
        lb_q    <= ax_q - bx_q;
        sumx_q  <= ax_q + bx_q;
        sumy_q  <= ay_q + by_q;
        degen_q <= (ax_q == bx_q) && (ay_q == by_q);
      end
      OP_TERMS: begin
        tx_q <= TW'(dx) * TW'(S1);
        ty_q <= TW'(dy) * TW'(S1);
      end
      OP_MULX: begin
        p_q <= PW'(la_q) * PW'(tx_q);
      end
      OP_MULY: begin
        frow_q <= f0;
        cur_q  <= f0;
        x_q    <= '0;
        y_q    <= '0;
        cnt_q  <= '0;
      end
      OP_SCAN: begin
        cnt_q <= cnt_q + CntW'(pos_hit);
        if (last_y) begin
          y_q    <= '0;
          x_q    <= x_q + 1'b1;
          frow_q <= ynext;
          cur_q  <= ynext;
        end else begin
          y_q   <= y_q + 1'b1;
          cur_q <= cur_q + ystep;
        end
      end
      OP_ACCUM: begin
        // first area counts the outside, second the inside
        if (!pix_q) begin
          a1_q <= a1_q + AreaW'(Full - ceff);
        end else begin
          a2_q <= a2_q + AreaW'(ceff);
        end
        pix_q <= ~pix_q;
      end
      OP_NSEG: begin
        k_q <= 1'b1;
      end
      OP_EMIT: begin
        if (!out_busy) begin
          out_q.area_first  <= two_q ? a1_q : (a1_q << 1);
          out_q.area_second <= two_q ? a2_q : (a2_q << 1);
        end
      end
      default: begin
      end
    endcase
  end

  // Output word valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.op == OP_EMIT && !out_busy) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offx_q <= '0;
      offy_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_OFFSET_X) begin
        offx_q <= cfg_wdata_i;
      end
      if (cfg_idx_i == REG_OFFSET_Y) begin
        offy_q <= cfg_wdata_i;
      end
    end
  end

`ifndef SYNTH
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("second word accepted while one is in work");

  a_valid_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(ctrl_i.op == OP_EMIT))
    else $error("result raised outside the emit step");
`endif

endmodule

FILE: src/diagonal_edge_area_calculator_core.sv
// Diagonal edge area calculator.
// Input channel (in_valid_i/in_ready_o, in_word_i) takes one word: edge
// pattern plus left and right distances. Output channel (out_valid_o/
// out_ready_i, out_word_o) returns the two coverage areas as numerators
// over 2*SAMPLES^2. cfg_we_i/cfg_idx_i/cfg_wdata_i write the x and y
// subsample offsets (signed Q.8); write them only while the block is idle.
// One word is in work at a time. A two-segment pattern scans samples for
// both segments and a one-segment pattern for one; the sample scan does
// one supersample test per cycle using additions only. The block is ready
// for the next word as soon as the result is loaded into the output
// register. When the receiver stalls, the result waits in the output
// register and a following word is still accepted and worked on; it only
// waits at the end for the register to free up.
// Reset clears the offsets to zero, the output register valid and the
// microprogram counter; the block is ready for a word right after reset.
module diagonal_edge_area_calculator_core
  import deac_pkg::*;
#(
  parameter int unsigned SAMPLES = SamplesDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_word_t        in_word_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_word_t       out_word_o,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [CfgW-1:0] cfg_wdata_i
);

  ctrl_t ctrl;
  stat_t stat;

  deac_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  deac_datapath #(
    .SAMPLES (SAMPLES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

endmodule
